@@ hdl/elm_pkg.sv @@
// Shared types, constants and sigmoid table for the ELM scorer.
`timescale 1ns / 1ps
`default_nettype none
package elm_pkg;

    // Default sizes for the top-level parameters.
    localparam int MaxFeaturesDef = 64;
    localparam int MaxHiddenDef   = 1024;
    localparam int MaxClassesDef  = 8;

    // Sigmoid lookup: entries cover [-8, +8], entry count a power of two.
    localparam int SigEntries = 256;
    localparam int SigBits    = $clog2(SigEntries);

    // Field widths of the channels.
    localparam int OP_W    = 2;
    localparam int HIDX_W  = 10;
    localparam int FIDX_W  = 6;
    localparam int CLS_W   = 3;
    localparam int VAL_W   = 16;
    localparam int SCORE_W = 42;
    localparam int CFGI_W  = 2;
    localparam int CFGD_W  = 11;

    // Widths of the clamped counts handed to the engine (cover every parameter value).
    localparam int FCNT_W = 9;
    localparam int HCNT_W = 13;
    localparam int CCNT_W = 5;

    localparam int PRODUCT_W = 33;

    typedef enum logic [OP_W-1:0] {
        K_WGT  = 2'd0,
        K_BIAS = 2'd1,
        K_OWGT = 2'd2,
        K_FEAT = 2'd3
    } t_kind;

    typedef enum logic [CFGI_W-1:0] {
        CFG_FEATURES = 2'd0,
        CFG_HIDDEN   = 2'd1,
        CFG_CLASSES  = 2'd2,
        CFG_NONE     = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        t_kind                     kind;
        logic [HIDX_W-1:0]         hidx;
        logic [FIDX_W-1:0]         fidx;
        logic [CLS_W-1:0]          cls;
        logic signed [VAL_W-1:0]   value;
        logic                      last;
        logic                      in_range;
    } t_cmd;

    typedef struct packed {
        logic [FCNT_W-1:0] fc;
        logic [HCNT_W-1:0] hc;
        logic [CCNT_W-1:0] cc;
    } t_counts;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HEAD,
        ST_BIAS,
        ST_MAC,
        ST_DRAIN,
        ST_ACT,
        ST_SIG,
        ST_OMAC,
        ST_ODRAIN,
        ST_EMIT
    } t_state;

    typedef logic [15:0] t_sig_tab [SigEntries];

    // Shift-subtract division, used only while building the table.
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], n[b]};
            if (rem >= {1'b0, d}) begin
                rem    = rem - {1'b0, d};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // exp(-t) in Q30: Taylor series on t/64, then squared six times.
    function automatic logic [63:0] exp_neg_q30(input logic [63:0] t);
        logic [63:0] a;
        logic [63:0] a2;
        logic [63:0] a3;
        logic [63:0] a4;
        logic [63:0] e;
        a  = t >> 6;
        a2 = (a * a) >> 30;
        a3 = (a2 * a) >> 30;
        a4 = (a3 * a) >> 30;
        e  = ((64'd1 << 30) - a) + (a2 >> 1) - a3 / 6 + a4 / 24;
        for (int k = 0; k < 6; k++) begin
            e = (e * e) >> 30;
        end
        return e;
    endfunction

    function automatic t_sig_tab sig_build();
        t_sig_tab    tab;
        logic [63:0] half;
        logic [63:0] num;
        logic [63:0] t;
        logic [63:0] e;
        logic [63:0] s;
        logic [63:0] q;
        logic        pos;
        half = 64'd8 << 30;
        for (int i = 0; i < SigEntries; i++) begin
            num = (64'(2 * i + 1) * half) >> SigBits;
            pos = num >= half;
            t   = pos ? num - half : half - num;
            e   = exp_neg_q30(t);
            s   = pos ? udiv64(64'd1 << 60, (64'd1 << 30) + e)
                      : udiv64(e << 30, (64'd1 << 30) + e);
            q   = (s + (64'd1 << 14)) >> 15;
            if (q > 64'd32767) begin
                q = 64'd32767;
            end
            tab[i] = q[15:0];
        end
        return tab;
    endfunction

    localparam t_sig_tab SIG_TAB = sig_build();

endpackage
`default_nettype wire

@@ hdl/elm_if.sv @@
// Handshake channel interfaces: input items, scores and configuration writes.
`timescale 1ns / 1ps
`default_nettype none
interface elm_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [elm_pkg::OP_W-1:0]             op;
    logic [elm_pkg::HIDX_W-1:0]           hidden_index;
    logic [elm_pkg::FIDX_W-1:0]           feature_index;
    logic [elm_pkg::CLS_W-1:0]            class_slot;
    logic signed [elm_pkg::VAL_W-1:0]     value;
    logic                                 last_feature;
    modport source (output valid, op, hidden_index, feature_index, class_slot, value,
                    last_feature, input ready);
    modport sink (input valid, op, hidden_index, feature_index, class_slot, value,
                  last_feature, output ready);
endinterface

interface elm_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [elm_pkg::SCORE_W-1:0]   score;
    logic [elm_pkg::CLS_W-1:0]            class_id;
    logic                                 last_score;
    modport source (output valid, score, class_id, last_score, input ready);
    modport sink (input valid, score, class_id, last_score, output ready);
endinterface

interface elm_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [elm_pkg::CFGI_W-1:0]           index;
    logic [elm_pkg::CFGD_W-1:0]           data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ hdl/elm_front.sv @@
// Front end: configuration registers, item decode and the command queue.
`timescale 1ns / 1ps
`default_nettype none
module elm_front #(
    parameter int MAX_FEATURES = elm_pkg::MaxFeaturesDef,
    parameter int MAX_HIDDEN   = elm_pkg::MaxHiddenDef,
    parameter int MAX_CLASSES  = elm_pkg::MaxClassesDef
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    elm_in_if.sink                 i_in,
    elm_cfg_if.sink                i_cfg,
    input  wire                    i_pop,
    output elm_pkg::t_cmd          o_cmd,
    output logic                   o_cmd_valid,
    output elm_pkg::t_counts       o_counts
);
    localparam int Depth     = 4;
    localparam int PtrW      = $clog2(Depth);
    localparam int ClassCap  = (MAX_CLASSES < 8) ? MAX_CLASSES : 8;

    logic [6:0]                r_fc_raw;
    logic [10:0]               r_hc_raw;
    logic [3:0]                r_cc_raw;
    elm_pkg::t_cmd             r_q [Depth];
    logic [PtrW-1:0]           r_wp;
    logic [PtrW-1:0]           r_rp;
    logic [PtrW:0]             r_cnt;
    elm_pkg::t_cmd             cmd_in;
    logic                      push;
    logic                      pop;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fc_raw <= 7'd60;
            r_hc_raw <= 11'd1000;
            r_cc_raw <= 4'd2;
        end else if (i_cfg.valid) begin
            case (elm_pkg::t_cfg_idx'(i_cfg.index))
                elm_pkg::CFG_FEATURES: r_fc_raw <= i_cfg.data[6:0];
                elm_pkg::CFG_HIDDEN:   r_hc_raw <= i_cfg.data;
                elm_pkg::CFG_CLASSES:  r_cc_raw <= i_cfg.data[3:0];
                default: ;
            endcase
        end
    end

    // Zero counts act as one, oversize counts saturate to the build size (classes to at most 8).
    always_comb begin
        if (r_fc_raw == '0) begin
            o_counts.fc = elm_pkg::FCNT_W'(1);
        end else if (32'(r_fc_raw) > MAX_FEATURES) begin
            o_counts.fc = elm_pkg::FCNT_W'(MAX_FEATURES);
        end else begin
            o_counts.fc = elm_pkg::FCNT_W'(r_fc_raw);
        end
        if (r_hc_raw == '0) begin
            o_counts.hc = elm_pkg::HCNT_W'(1);
        end else if (32'(r_hc_raw) > MAX_HIDDEN) begin
            o_counts.hc = elm_pkg::HCNT_W'(MAX_HIDDEN);
        end else begin
            o_counts.hc = elm_pkg::HCNT_W'(r_hc_raw);
        end
        if (r_cc_raw == '0) begin
            o_counts.cc = elm_pkg::CCNT_W'(1);
        end else if (32'(r_cc_raw) > ClassCap) begin
            o_counts.cc = elm_pkg::CCNT_W'(ClassCap);
        end else begin
            o_counts.cc = elm_pkg::CCNT_W'(r_cc_raw);
        end
    end

    // Classify the beat and flag addresses outside the memories.
    always_comb begin
        cmd_in.kind  = elm_pkg::t_kind'(i_in.op);
        cmd_in.hidx  = i_in.hidden_index;
        cmd_in.fidx  = i_in.feature_index;
        cmd_in.cls   = i_in.class_slot;
        cmd_in.value = i_in.value;
        cmd_in.last  = i_in.last_feature;
        case (elm_pkg::t_kind'(i_in.op))
            elm_pkg::K_WGT:  cmd_in.in_range = (32'(i_in.hidden_index) < MAX_HIDDEN) &&
                                               (32'(i_in.feature_index) < MAX_FEATURES);
            elm_pkg::K_BIAS: cmd_in.in_range = 32'(i_in.hidden_index) < MAX_HIDDEN;
            elm_pkg::K_OWGT: cmd_in.in_range = (32'(i_in.hidden_index) < MAX_HIDDEN) &&
                                               (32'(i_in.class_slot) < MAX_CLASSES);
            elm_pkg::K_FEAT: cmd_in.in_range = 32'(i_in.feature_index) < MAX_FEATURES;
            default:         cmd_in.in_range = 1'b0;
        endcase
    end

    assign i_in.ready  = r_cnt != (PtrW+1)'(Depth);
    assign push        = i_in.valid && i_in.ready;
    assign pop         = i_pop && o_cmd_valid;
    assign o_cmd_valid = r_cnt != '0;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

@@ hdl/elm_core.sv @@
// Back end: weight memories, shared multiply-accumulate and score output.
`timescale 1ns / 1ps
`default_nettype none
module elm_core #(
    parameter int MAX_FEATURES = elm_pkg::MaxFeaturesDef,
    parameter int MAX_HIDDEN   = elm_pkg::MaxHiddenDef,
    parameter int MAX_CLASSES  = elm_pkg::MaxClassesDef
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  elm_pkg::t_cmd          i_cmd,
    input  wire                    i_cmd_valid,
    input  elm_pkg::t_counts       i_counts,
    output logic                   o_pop,
    elm_out_if.source              o_out
);
    localparam int FW  = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int HW  = (MAX_HIDDEN > 1) ? $clog2(MAX_HIDDEN) : 1;
    localparam int CW  = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
    localparam int KW  = ((FW > CW) ? FW : CW) + 1;
    localparam int PW  = 32 + FW + 2;
    localparam int SW  = elm_pkg::SCORE_W;
    localparam int XW  = elm_pkg::PRODUCT_W;
    localparam int WDepth = MAX_HIDDEN * (1 << FW);
    localparam int ODepth = MAX_HIDDEN * (1 << CW);
    localparam logic signed [PW-1:0] PreLimit = PW'(64'sd1 <<< 27);
    localparam logic signed [SW:0]   ScoreMax = (SW+1)'((64'sd1 <<< (SW-1)) - 1);
    localparam logic signed [SW:0]   ScoreMin = -(SW+1)'(64'sd1 <<< (SW-1));
    localparam int SigBitsW = elm_pkg::SigBits;

    logic signed [15:0]  r_wmem [WDepth];
    logic signed [15:0]  r_bmem [MAX_HIDDEN];
    logic signed [15:0]  r_omem [ODepth];
    logic signed [15:0]  r_fbuf [MAX_FEATURES];
    logic signed [SW-1:0] r_acc [MAX_CLASSES];

    elm_pkg::t_state     r_state;
    elm_pkg::t_state     n_state;
    elm_pkg::t_counts    r_cnts;
    logic [HW:0]         r_j;
    logic [KW-1:0]       r_k;
    logic signed [PW-1:0] r_pre;
    logic [SigBitsW-1:0] r_idx;
    logic [15:0]         r_sig;
    logic signed [15:0]  r_wq;
    logic signed [15:0]  r_fq;
    logic signed [15:0]  r_bq;
    logic signed [15:0]  r_oq;
    logic                r_v1;
    logic                r_m1;
    logic [CW-1:0]       r_t1;
    logic                r_v2;
    logic                r_m2;
    logic [CW-1:0]       r_t2;
    logic signed [XW-1:0] r_prod;
    logic                r_ov;
    logic signed [SW-1:0] r_score;
    logic [elm_pkg::CLS_W-1:0] r_cid;
    logic                r_last;

    logic                start;
    logic                issue_h;
    logic                issue_o;
    logic                mac_done;
    logic                omac_done;
    logic                busy;
    logic                emit_go;
    logic                last_j;
    logic                last_k;
    logic [CW-1:0]       acc_ra;
    logic signed [SW-1:0] acc_rd;
    logic signed [SW:0]  acc_sum;
    logic signed [SW-1:0] acc_sat;
    logic signed [PW-1:0] pre_cl;
    logic [28:0]         pre_u;
    logic signed [XW-1:0] prod;

    // Control strobes.
    always_comb begin
        o_pop     = (r_state == elm_pkg::ST_IDLE) && i_cmd_valid;
        start     = o_pop && (i_cmd.kind == elm_pkg::K_FEAT) && i_cmd.last;
        issue_h   = r_state == elm_pkg::ST_MAC;
        issue_o   = r_state == elm_pkg::ST_OMAC;
        mac_done  = issue_h && (elm_pkg::FCNT_W'(r_k) == r_cnts.fc - 1'b1);
        last_k    = elm_pkg::CCNT_W'(r_k) == r_cnts.cc - 1'b1;
        omac_done = issue_o && last_k;
        busy      = r_v1 || r_v2;
        emit_go   = (r_state == elm_pkg::ST_EMIT) && (!r_ov || o_out.ready);
        last_j    = elm_pkg::HCNT_W'(r_j) == r_cnts.hc - 1'b1;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            elm_pkg::ST_IDLE:   if (start) n_state = elm_pkg::ST_HEAD;
            elm_pkg::ST_HEAD:   n_state = elm_pkg::ST_BIAS;
            elm_pkg::ST_BIAS:   n_state = elm_pkg::ST_MAC;
            elm_pkg::ST_MAC:    if (mac_done) n_state = elm_pkg::ST_DRAIN;
            elm_pkg::ST_DRAIN:  if (!busy) n_state = elm_pkg::ST_ACT;
            elm_pkg::ST_ACT:    n_state = elm_pkg::ST_SIG;
            elm_pkg::ST_SIG:    n_state = elm_pkg::ST_OMAC;
            elm_pkg::ST_OMAC:   if (omac_done) n_state = elm_pkg::ST_ODRAIN;
            elm_pkg::ST_ODRAIN: begin
                if (!busy) begin
                    n_state = last_j ? elm_pkg::ST_EMIT : elm_pkg::ST_HEAD;
                end
            end
            elm_pkg::ST_EMIT:   if (emit_go && last_k) n_state = elm_pkg::ST_IDLE;
            default:            n_state = elm_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= elm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Memory writes from the queue, reads at the sequencer address.
    always_ff @(posedge i_clk) begin
        if (o_pop && i_cmd.in_range) begin
            case (i_cmd.kind)
                elm_pkg::K_WGT:  r_wmem[{HW'(i_cmd.hidx), FW'(i_cmd.fidx)}] <= i_cmd.value;
                elm_pkg::K_BIAS: r_bmem[HW'(i_cmd.hidx)] <= i_cmd.value;
                elm_pkg::K_OWGT: r_omem[{HW'(i_cmd.hidx), CW'(i_cmd.cls)}] <= i_cmd.value;
                elm_pkg::K_FEAT: r_fbuf[FW'(i_cmd.fidx)] <= i_cmd.value;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_wq <= r_wmem[{r_j[HW-1:0], r_k[FW-1:0]}];
        r_fq <= r_fbuf[r_k[FW-1:0]];
        r_bq <= r_bmem[r_j[HW-1:0]];
        r_oq <= r_omem[{r_j[HW-1:0], r_k[CW-1:0]}];
    end

    // Activation: clamp to +/-8, bin into the table.
    always_comb begin
        if (r_pre > PreLimit) begin
            pre_cl = PreLimit;
        end else if (r_pre < -PreLimit) begin
            pre_cl = -PreLimit;
        end else begin
            pre_cl = r_pre;
        end
        pre_u = 29'(pre_cl + PreLimit);
    end

    always_comb begin
        if (r_m1) begin
            prod = XW'($signed({1'b0, r_sig}) * r_oq);
        end else begin
            prod = XW'(r_wq * r_fq);
        end
    end

    assign acc_ra  = (r_state == elm_pkg::ST_EMIT) ? r_k[CW-1:0] : r_t2;
    assign acc_rd  = r_acc[acc_ra];
    assign acc_sum = (SW+1)'(acc_rd) + (SW+1)'(r_prod);
    always_comb begin
        if (acc_sum > ScoreMax) begin
            acc_sat = SW'(ScoreMax);
        end else if (acc_sum < ScoreMin) begin
            acc_sat = SW'(ScoreMin);
        end else begin
            acc_sat = SW'(acc_sum);
        end
    end

    // Multiply pipeline: operand read, product, accumulate.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= issue_h || issue_o;
            r_v2 <= r_v1;
        end
        r_m1   <= issue_o;
        r_t1   <= r_k[CW-1:0];
        r_m2   <= r_m1;
        r_t2   <= r_t1;
        r_prod <= prod;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < MAX_CLASSES; c++) begin
                r_acc[c] <= '0;
            end
        end else if (start) begin
            for (int c = 0; c < MAX_CLASSES; c++) begin
                r_acc[c] <= '0;
            end
        end else if (r_v2 && r_m2) begin
            r_acc[r_t2] <= acc_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j <= '0;
            r_k <= '0;
        end else begin
            case (r_state)
                elm_pkg::ST_IDLE: begin
                    if (start) begin
                        r_cnts <= i_counts;
                        r_j    <= '0;
                    end
                end
                elm_pkg::ST_BIAS: begin
                    r_pre <= PW'(r_bq) <<< 12;
                    r_k   <= '0;
                end
                elm_pkg::ST_MAC:  r_k <= r_k + 1'b1;
                elm_pkg::ST_ACT: begin
                    if (pre_u[28]) begin
                        r_idx <= '1;
                    end else begin
                        r_idx <= SigBitsW'(pre_u >> (28 - SigBitsW));
                    end
                end
                elm_pkg::ST_SIG: begin
                    r_sig <= elm_pkg::SIG_TAB[r_idx];
                    r_k   <= '0;
                end
                elm_pkg::ST_OMAC: r_k <= r_k + 1'b1;
                elm_pkg::ST_ODRAIN: begin
                    if (!busy) begin
                        r_k <= '0;
                        if (!last_j) begin
                            r_j <= r_j + 1'b1;
                        end
                    end
                end
                elm_pkg::ST_EMIT: if (emit_go) r_k <= r_k + 1'b1;
                default: ;
            endcase
            if (r_v2 && !r_m2) begin
                r_pre <= r_pre + PW'(r_prod);
            end
        end
    end

    // Output register: load a score whenever the slot is free or being taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (emit_go) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
        if (emit_go) begin
            r_score <= acc_rd;
            r_cid   <= elm_pkg::CLS_W'(r_k);
            r_last  <= last_k;
        end
    end

    assign o_out.valid      = r_ov;
    assign o_out.score      = r_score;
    assign o_out.class_id   = r_cid;
    assign o_out.last_score = r_last;

endmodule
`default_nettype wire

@@ hdl/elm_inference_scorer.sv @@
// Top level of the ELM scorer: front end, command queue and scoring engine.
//
// Input channel i_in: each beat is an op. Ops 0..2 write an input weight,
// a hidden bias or an output weight; op 3 stores a feature, and with
// last_feature set it scores the sample. Output channel o_out carries one
// beat per class (class_count beats), last_score on the final one.
// Config channel i_cfg writes feature_count, hidden_count, class_count at
// index 0, 1, 2; it is always ready and must only be used while idle.
// Beats enter a four-entry queue; write ops retire from it while the engine is idle.
// A single shared multiplier does every hidden and output product of a
// scoring sample in turn. During scoring the queue keeps taking beats
// until it fills. Reset sets the counts to 60, 1000 and 2 and empties
// the queue; memories hold whatever was last written. When the receiver
// stalls, the engine holds the next score until o_out.ready.
`timescale 1ns / 1ps
`default_nettype none
module elm_inference_scorer #(
    parameter int MAX_FEATURES = elm_pkg::MaxFeaturesDef,
    parameter int MAX_HIDDEN   = elm_pkg::MaxHiddenDef,
    parameter int MAX_CLASSES  = elm_pkg::MaxClassesDef
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    elm_in_if.sink     i_in,
    elm_cfg_if.sink    i_cfg,
    elm_out_if.source  o_out
);
    elm_pkg::t_cmd     cmd;
    elm_pkg::t_counts  counts;
    logic              cmd_valid;
    logic              pop;

    elm_front #(
        .MAX_FEATURES (MAX_FEATURES),
        .MAX_HIDDEN   (MAX_HIDDEN),
        .MAX_CLASSES  (MAX_CLASSES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg       (i_cfg),
        .i_pop       (pop),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .o_counts    (counts)
    );

    elm_core #(
        .MAX_FEATURES (MAX_FEATURES),
        .MAX_HIDDEN   (MAX_HIDDEN),
        .MAX_CLASSES  (MAX_CLASSES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .i_counts    (counts),
        .o_pop       (pop),
        .o_out       (o_out)
    );

endmodule
`default_nettype wire

@@ test/tb.sv @@
// Self-checking testbench for elm_inference_scorer: random and directed beats against a predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb;

    localparam int NFEAT      = 64;
    localparam int NHID       = 1024;
    localparam int NCLS       = 8;
    localparam int NSIG       = 256;
    localparam int FILL_HID   = 6;
    localparam int FILL_FEAT  = 8;
    localparam longint CYCLE_LIMIT = 3000000;
    localparam int IDLE_SETTLE = 40;
    localparam int LONG_HOLD   = 3000;

    typedef struct {
        logic [elm_pkg::SCORE_W-1:0] score;
        logic [elm_pkg::CLS_W-1:0]   class_id;
        logic                        last_score;
    } t_score;

    class elm_scoreboard;
        shortint in_wt [NFEAT*NHID];
        shortint bias [NHID];
        shortint out_wt [NHID*NCLS];
        shortint feat [NFEAT];
        int unsigned sig_lut [NSIG];
        int unsigned feat_cnt, hid_cnt, cls_cnt;
        t_score expected_scores [$];
        int errors;

        function new();
            longint unsigned half, num, t, a, a2, a3, a4, e, s, q, one;
            bit pos;
            one = 64'd1 << 30;
            half = 64'd8 << 30;
            for (int i = 0; i < NSIG; i++) begin
                num = (longint'(2 * i + 1) * half) / NSIG;
                pos = num >= half;
                t = pos ? num - half : half - num;
                a = t >> 6;
                a2 = (a * a) >> 30;
                a3 = (a2 * a) >> 30;
                a4 = (a3 * a) >> 30;
                e = ((one - a) + a2 / 2) - a3 / 6 + a4 / 24;
                for (int k = 0; k < 6; k++) e = (e * e) >> 30;
                s = pos ? (64'd1 << 60) / (one + e) : (e << 30) / (one + e);
                q = (s + (64'd1 << 14)) >> 15;
                if (q > 32767) q = 32767;
                sig_lut[i] = 32'(q);
            end
            feat_cnt = 60;
            hid_cnt = 1000;
            cls_cnt = 2;
            errors = 0;
        endfunction

        function automatic int unsigned clamp_cnt(int unsigned v, int unsigned cap);
            if (v < 1) return 1;
            return (v > cap) ? cap : v;
        endfunction

        function void write_reg(elm_pkg::t_cfg_idx idx, logic [elm_pkg::CFGD_W-1:0] data);
            case (idx)
                elm_pkg::CFG_FEATURES: feat_cnt = 32'(data & 11'h7f);
                elm_pkg::CFG_HIDDEN:   hid_cnt = 32'(data & 11'h7ff);
                elm_pkg::CFG_CLASSES:  cls_cnt = 32'(data & 11'hf);
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_scores.size();
        endfunction

        function void note_item(elm_pkg::t_kind op, int h, int f, int c, shortint v, bit last);
            int unsigned fc, hc, cc, idx;
            longint acc [NCLS];
            longint pre, lim, sg;
            t_score r;
            case (op)
                elm_pkg::K_WGT:  begin in_wt[h*NFEAT + f] = v; return; end
                elm_pkg::K_BIAS: begin bias[h] = v; return; end
                elm_pkg::K_OWGT: begin out_wt[h*NCLS + c] = v; return; end
                default: feat[f] = v;
            endcase
            if (!last) return;
            fc = clamp_cnt(feat_cnt, NFEAT);
            hc = clamp_cnt(hid_cnt, NHID);
            cc = clamp_cnt(cls_cnt, NCLS);
            lim = 64'sd8 << 24;
            for (int k = 0; k < NCLS; k++) acc[k] = 0;
            for (int j = 0; j < hc; j++) begin
                pre = longint'(bias[j]) * 4096;
                for (int k = 0; k < fc; k++)
                    pre += longint'(in_wt[j*NFEAT + k]) * longint'(feat[k]);
                if (pre > lim) pre = lim;
                if (pre < -lim) pre = -lim;
                idx = 32'(((pre + lim) * NSIG) >>> 28);
                if (idx > NSIG - 1) idx = NSIG - 1;
                sg = longint'(sig_lut[idx]);
                for (int k = 0; k < cc; k++) begin
                    acc[k] += sg * longint'(out_wt[j*NCLS + k]);
                    if (acc[k] > (64'sd1 << 41) - 1) acc[k] = (64'sd1 << 41) - 1;
                    if (acc[k] < -(64'sd1 << 41)) acc[k] = -(64'sd1 << 41);
                end
            end
            for (int k = 0; k < cc; k++) begin
                r.score = acc[k][elm_pkg::SCORE_W-1:0];
                r.class_id = elm_pkg::CLS_W'(k);
                r.last_score = (k == cc - 1);
                expected_scores.push_back(r);
            end
        endfunction

        function void check_score(logic [elm_pkg::SCORE_W-1:0] score,
                                  logic [elm_pkg::CLS_W-1:0] cid, logic last);
            t_score e;
            if (expected_scores.size() == 0) begin
                $error("score beat with nothing expected: class_id %0d", cid);
                errors++;
                return;
            end
            e = expected_scores.pop_front();
            if (score !== e.score) begin
                $error("score: expected %0d actual %0d", $signed(e.score), $signed(score));
                errors++;
            end
            if (cid !== e.class_id) begin
                $error("class_id: expected %0d actual %0d", e.class_id, cid);
                errors++;
            end
            if (last !== e.last_score) begin
                $error("last_score: expected %0d actual %0d", e.last_score, last);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    elm_in_if  in_ch ();
    elm_cfg_if cfg_ch ();
    elm_out_if out_ch ();

    elm_inference_scorer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .i_cfg   (cfg_ch.sink),
        .o_out   (out_ch.source)
    );

    elm_scoreboard sb;
    bit gaps_on;
    bit hold_req;
    bit hold_done;
    int scores_seen;
    longint cycle_cnt;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            sb.check_score(out_ch.score, out_ch.class_id, out_ch.last_score);
            scores_seen++;
        end
    end

    // Sink side: random stalls, plus one long hold-off to back up the queue.
    initial begin
        int stall;
        stall = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done && out_ch.valid) begin
                hold_done = 1;
                out_ch.ready = 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
            end
            if (stall > 0) begin
                stall--;
                out_ch.ready = 1'b0;
            end else begin
                stall = pick_gap();
                out_ch.ready = (stall == 0) || ($urandom_range(1) == 1);
            end
        end
    end

    task automatic send_item(elm_pkg::t_kind op, int h, int f, int c, shortint v, bit last);
        int gap;
        in_ch.op = op;
        in_ch.hidden_index = elm_pkg::HIDX_W'(h);
        in_ch.feature_index = elm_pkg::FIDX_W'(f);
        in_ch.class_slot = elm_pkg::CLS_W'(c);
        in_ch.value = v;
        in_ch.last_feature = last;
        in_ch.valid = 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_item(op, h, f, c, v, last);
        @(negedge i_clk);
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic end_burst();
        in_ch.valid = 1'b0;
    endtask

    task automatic wait_idle();
        end_burst();
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (IDLE_SETTLE) @(negedge i_clk);
    endtask

    task automatic write_cfg(elm_pkg::t_cfg_idx idx, int data);
        cfg_ch.index = idx;
        cfg_ch.data = elm_pkg::CFGD_W'(data);
        cfg_ch.valid = 1'b1;
        do @(posedge i_clk); while (!cfg_ch.ready);
        sb.write_reg(idx, elm_pkg::CFGD_W'(data));
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic set_counts(int fc, int hc, int cc);
        write_cfg(elm_pkg::CFG_FEATURES, fc);
        write_cfg(elm_pkg::CFG_HIDDEN, hc);
        write_cfg(elm_pkg::CFG_CLASSES, cc);
    endtask

    function automatic shortint rand_val();
        int r;
        r = $urandom_range(9);
        if (r == 0) return 16'sh7fff;
        if (r == 1) return 16'sh8000;
        return shortint'($urandom());
    endfunction

    // Mostly in-range writes and feature streams; a few wide-address writes.
    task automatic random_phase(int n_items, int hc);
        int r, h;
        for (int i = 0; i < n_items; i++) begin
            r = $urandom_range(99);
            h = ($urandom_range(3) == 0) ? $urandom_range(NHID - 1) : $urandom_range(hc - 1);
            if (r < 15)
                send_item(elm_pkg::K_WGT, h, $urandom_range(NFEAT - 1), 0, rand_val(),
                          1'($urandom_range(1)));
            else if (r < 25)
                send_item(elm_pkg::K_BIAS, h, $urandom_range(NFEAT - 1),
                          $urandom_range(NCLS - 1), rand_val(), 1'($urandom_range(1)));
            else if (r < 40)
                send_item(elm_pkg::K_OWGT, h, 0, $urandom_range(NCLS - 1), rand_val(),
                          1'($urandom_range(1)));
            else
                send_item(elm_pkg::K_FEAT, $urandom_range(NHID - 1), $urandom_range(NFEAT - 1),
                          $urandom_range(NCLS - 1), rand_val(), $urandom_range(3) == 0);
        end
        send_item(elm_pkg::K_FEAT, 0, $urandom_range(NFEAT - 1), 0, rand_val(), 1'b1);
    endtask

    initial begin
        sb = new();
        gaps_on = 0;
        hold_req = 0;
        hold_done = 0;
        scores_seen = 0;
        cycle_cnt = 0;
        in_ch.valid = 1'b0;
        in_ch.op = elm_pkg::K_WGT;
        in_ch.hidden_index = '0;
        in_ch.feature_index = '0;
        in_ch.class_slot = '0;
        in_ch.value = '0;
        in_ch.last_feature = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = elm_pkg::CFG_FEATURES;
        cfg_ch.data = '0;
        i_rst_n = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Fill the region that later samples read; counts stay inside it.
        for (int h = 0; h < FILL_HID; h++) begin
            for (int f = 0; f < FILL_FEAT; f++)
                send_item(elm_pkg::K_WGT, h, f, 0, shortint'($urandom()), 1'b0);
            send_item(elm_pkg::K_BIAS, h, 0, 0, shortint'($urandom()), 1'b0);
            for (int c = 0; c < NCLS; c++)
                send_item(elm_pkg::K_OWGT, h, 0, c, shortint'($urandom()), 1'b0);
        end
        for (int f = 0; f < FILL_FEAT; f++)
            send_item(elm_pkg::K_FEAT, 0, f, 0, shortint'($urandom()), 1'b0);
        wait_idle();

        // Directed: extreme values, every op, last flag on write ops.
        gaps_on = 1;
        set_counts(4, 3, 8);
        send_item(elm_pkg::K_WGT, 0, 0, 0, 16'sh7fff, 1'b1);
        send_item(elm_pkg::K_WGT, 1023, 63, 7, 16'sh8000, 1'b0);
        send_item(elm_pkg::K_BIAS, 1, 0, 0, 16'sh7fff, 1'b1);
        send_item(elm_pkg::K_BIAS, 1023, 0, 0, 16'sh8000, 1'b0);
        send_item(elm_pkg::K_OWGT, 0, 0, 7, 16'sh7fff, 1'b1);
        send_item(elm_pkg::K_OWGT, 1023, 0, 7, 16'sh8000, 1'b0);
        send_item(elm_pkg::K_FEAT, 0, 0, 0, 16'sh7fff, 1'b0);
        send_item(elm_pkg::K_FEAT, 1023, 63, 7, 16'sh8000, 1'b0);
        send_item(elm_pkg::K_FEAT, 0, 1, 0, 16'sh7fff, 1'b1);
        send_item(elm_pkg::K_FEAT, 0, 0, 0, 16'sh8000, 1'b1);
        send_item(elm_pkg::K_FEAT, 0, 2, 0, 16'sh0000, 1'b1);
        send_item(elm_pkg::K_FEAT, 0, 3, 0, 16'shffff, 1'b1);
        wait_idle();
        // Zero counts act as one; an oversize class count saturates.
        set_counts(0, 0, 0);
        send_item(elm_pkg::K_FEAT, 0, 0, 0, 16'sh1000, 1'b1);
        wait_idle();
        set_counts(0, 0, 15);
        send_item(elm_pkg::K_FEAT, 0, 0, 0, 16'sh8000, 1'b1);
        wait_idle();

        // Back-to-back samples while the receiver holds off: the queue fills.
        set_counts(1, 1, 1);
        hold_req = 1;
        for (int i = 0; i < 8; i++)
            send_item(elm_pkg::K_FEAT, 0, 0, 0, rand_val(), 1'b1);
        wait_idle();

        // Random part: several small settings inside the filled region.
        set_counts(3, 4, 2);
        random_phase(15, 4);
        wait_idle();
        set_counts(8, 6, 8);
        random_phase(15, 6);
        wait_idle();
        set_counts(1, 1, 1);
        random_phase(10, 1);
        wait_idle();
        set_counts(5, 6, 5);
        random_phase(15, 6);
        wait_idle();
        set_counts($urandom_range(FILL_FEAT, 1), $urandom_range(FILL_HID, 1),
                   $urandom_range(8, 1));
        random_phase(10, 1);
        wait_idle();
        set_counts(FILL_FEAT, FILL_HID, 8);
        send_item(elm_pkg::K_FEAT, 0, $urandom_range(FILL_FEAT - 1), 0, rand_val(), 1'b1);
        wait_idle();
        repeat (100) @(negedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("No mismatches found");
        else begin
            if (sb.pending() != 0) $error("%0d scores never arrived", sb.pending());
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
`default_nettype wire

@@ files.f @@
hdl/elm_pkg.sv
hdl/elm_if.sv
hdl/elm_front.sv
hdl/elm_core.sv
hdl/elm_inference_scorer.sv
test/tb.sv
